FILE: hw/rtl/zcrw_pkg.sv
package zcrw_pkg;

   localparam int MAX_WINDOW_DEF  = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int              WS_W     = 13;
   localparam logic [WS_W-1:0] WS_RESET = 13'd480;

   localparam int RATE_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_WINDOW_SIZE = 1'b0;

   typedef enum logic [1:0] {
      SIGN_ZERO = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } sign_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic     done;
      sign_type sign;
   } scan_status_type;

   typedef struct packed {
      logic              done;
      logic [RATE_W-1:0] quotient;
   } div_status_type;

endpackage

FILE: hw/rtl/zero_crossing_rate_window_core.sv
// Each accepted beat is scanned one sample bit per cycle and gives one result beat; a beat that
// closes a window also runs the bit-serial Q0.16 divider before its result beat.
// A new beat is accepted only once the previous one has loaded its result, so a waiting
// result that is not taken stalls the next scan.
// Reset: synchronous, active high; clears sign history, window count, sum and held
// rate, and sets window_size to 480.
module zero_crossing_rate_window_core #(
   parameter int MAX_WINDOW  = zcrw_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = zcrw_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,   // sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [zcrw_pkg::RATE_W-1:0]         rsp_tdata,   // crossing_rate
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [zcrw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [zcrw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [zcrw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int MW_BITS = $clog2(MAX_WINDOW + 1);
   localparam int WIN_W   = (MW_BITS > zcrw_pkg::WS_W) ? MW_BITS : zcrw_pkg::WS_W;
   localparam int SUM_W   = MW_BITS;
   localparam int CNT_W   = $clog2(MAX_WINDOW);

   zcrw_pkg::state_type       state_ff, state_in;
   zcrw_pkg::sign_type        prev_sign_ff, prev_sign_in;
   zcrw_pkg::scan_status_type scan_st;
   zcrw_pkg::div_status_type  div_st;

   logic [zcrw_pkg::WS_W-1:0]   window_size;
   logic [WIN_W-1:0]            win_eff;
   logic                        zero_run_ff, zero_run_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [SUM_W-1:0]            sum_ff, sum_in, sum_new;
   logic [zcrw_pkg::RATE_W-1:0] held_ff, held_in;
   logic                        close_ff, close_in, close_now;
   logic                        event_now;
   logic                        scan_start, div_start, out_load;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [zcrw_pkg::RATE_W-1:0] rsp_rate_ff, rsp_rate_in;
   logic                        rsp_last_ff, rsp_last_in;

   zcrw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .window_size (window_size)
   );

   zcrw_sign_scan #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .sample (req_tdata[SAMPLE_BITS-1:0]),
      .status (scan_st)
   );

   zcrw_divider #(
      .SUM_W (SUM_W),
      .WIN_W (WIN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (win_eff),
      .status   (div_st)
   );

   always_comb begin
      if (window_size == '0) begin
         win_eff = WIN_W'(1);
      end else if (WIN_W'(window_size) > WIN_W'(MAX_WINDOW)) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = WIN_W'(window_size);
      end
   end

   always_comb begin
      event_now = 1'b0;
      if (scan_st.sign == zcrw_pkg::SIGN_ZERO) begin
         event_now = !zero_run_ff;
      end else if ((scan_st.sign == zcrw_pkg::SIGN_POS && prev_sign_ff == zcrw_pkg::SIGN_NEG) ||
                   (scan_st.sign == zcrw_pkg::SIGN_NEG && prev_sign_ff == zcrw_pkg::SIGN_POS)) begin
         event_now = 1'b1;
      end
      sum_new   = sum_ff + SUM_W'(event_now);
      close_now = (WIN_W'(count_ff) + WIN_W'(1)) >= win_eff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         zcrw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = zcrw_pkg::ST_SCAN;
            end
         end
         zcrw_pkg::ST_SCAN: begin
            if (scan_st.done) begin
               state_in = close_now ? zcrw_pkg::ST_DIV : zcrw_pkg::ST_OUT;
            end
         end
         zcrw_pkg::ST_DIV: begin
            if (div_st.done) begin
               state_in = zcrw_pkg::ST_OUT;
            end
         end
         zcrw_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = zcrw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = zcrw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      scan_start = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         zcrw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            scan_start = req_tvalid;
         end
         zcrw_pkg::ST_SCAN: begin
            div_start = scan_st.done & close_now;
         end
         zcrw_pkg::ST_DIV: begin
            div_start = 1'b0;
         end
         zcrw_pkg::ST_OUT: begin
            out_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      prev_sign_in = prev_sign_ff;
      zero_run_in  = zero_run_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      held_in      = held_ff;
      close_in     = close_ff;
      if (state_ff == zcrw_pkg::ST_SCAN && scan_st.done) begin
         prev_sign_in = scan_st.sign;
         zero_run_in  = scan_st.sign == zcrw_pkg::SIGN_ZERO;
         close_in     = close_now;
         if (close_now) begin
            count_in = '0;
            sum_in   = '0;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_new;
         end
      end
      if (state_ff == zcrw_pkg::ST_DIV && div_st.done) begin
         held_in = div_st.quotient;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_rate_in  = held_ff;
         rsp_last_in  = close_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zcrw_pkg::ST_IDLE;
         prev_sign_ff <= zcrw_pkg::SIGN_ZERO;
         zero_run_ff  <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         held_ff      <= '0;
         close_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_sign_ff <= prev_sign_in;
         zero_run_ff  <= zero_run_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         held_ff      <= held_in;
         close_ff     <= close_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_rate_ff <= rsp_rate_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rate_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hw/rtl/zcrw_sign_scan.sv
module zcrw_sign_scan #(
   parameter int SAMPLE_BITS = zcrw_pkg::SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SAMPLE_BITS-1:0]   sample,
   output zcrw_pkg::scan_status_type status
);

   localparam int CNT_W = $clog2(SAMPLE_BITS);

   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   neg_ff, neg_in;
   logic                   nz_ff, nz_in;

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      nz_in    = nz_ff;
      if (start) begin
         shift_in = sample;
         cnt_in   = '0;
         busy_in  = 1'b1;
         nz_in    = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            neg_in = shift_ff[SAMPLE_BITS-1];
         end
         nz_in    = nz_ff | shift_ff[SAMPLE_BITS-1];
         shift_in = {shift_ff[SAMPLE_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SAMPLE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      neg_ff   <= neg_in;
      nz_ff    <= nz_in;
   end

   always_comb begin
      status.done = done_ff;
      if (!nz_ff) begin
         status.sign = zcrw_pkg::SIGN_ZERO;
      end else if (neg_ff) begin
         status.sign = zcrw_pkg::SIGN_NEG;
      end else begin
         status.sign = zcrw_pkg::SIGN_POS;
      end
   end

endmodule

FILE: hw/rtl/zcrw_divider.sv
module zcrw_divider #(
   parameter int SUM_W = 13,
   parameter int WIN_W = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [SUM_W-1:0]        dividend,
   input  logic [WIN_W-1:0]        divisor,
   output zcrw_pkg::div_status_type status
);

   localparam int QW    = zcrw_pkg::RATE_W;
   localparam int CNT_W = $clog2(QW);

   logic [WIN_W:0]   rem_ff, rem_in;
   logic [WIN_W-1:0] div_ff, div_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             sat_ff, sat_in;
   logic [WIN_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      trial   = {rem_ff[WIN_W-1:0], 1'b0};
      if (start) begin
         rem_in  = (WIN_W+1)'(dividend);
         div_in  = divisor;
         sat_in  = WIN_W'(dividend) >= divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = sat_ff ? '1 : quo_ff;

endmodule

FILE: hw/rtl/zcrw_csr.sv
module zcrw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [zcrw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [zcrw_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [zcrw_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [zcrw_pkg::WS_W-1:0]           window_size
);

   logic [zcrw_pkg::WS_W-1:0] window_size_ff, window_size_in;
   logic                      wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      window_size_in = window_size_ff;
      prdata         = '0;
      unique case (paddr[2])
         zcrw_pkg::REG_WINDOW_SIZE: begin
            prdata = zcrw_pkg::CSR_DATA_W'(window_size_ff);
            if (wr_en) begin
               window_size_in = pwdata[zcrw_pkg::WS_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= zcrw_pkg::WS_RESET;
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   assign window_size = window_size_ff;

endmodule

FILE: tb/sv/zero_crossing_rate_window_core_tb.sv
`timescale 1ns / 100ps

module zero_crossing_rate_window_core_tb;

   localparam int SAMPLE_W     = zcrw_pkg::SAMPLE_BITS_DEF;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_PCT     = 35;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT_BEAT = 200;

   typedef struct packed {
      logic [zcrw_pkg::RATE_W-1:0] rate;
      logic                        window_end;
   } rate_beat_type;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_tvalid  = 1'b0;
   logic                              req_tready;
   logic [SAMPLE_W-1:0]               req_tdata   = '0;   // sample
   logic                              rsp_tvalid;
   logic                              rsp_tready  = 1'b0;
   logic [zcrw_pkg::RATE_W-1:0]       rsp_tdata;          // crossing_rate
   logic                              rsp_tlast;
   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [zcrw_pkg::CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [zcrw_pkg::CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [zcrw_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   zero_crossing_rate_window_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [SAMPLE_W-1:0] sample_q[$];
   rate_beat_type       rate_q[$];

   logic [zcrw_pkg::WS_W-1:0]   window_size_reg = zcrw_pkg::WS_RESET;
   zcrw_pkg::sign_type          last_sign       = zcrw_pkg::SIGN_ZERO;
   logic                        zero_run        = 1'b0;
   logic [11:0]                 window_fill     = '0;
   logic [12:0]                 crossing_sum    = '0;
   logic [zcrw_pkg::RATE_W-1:0] held_rate       = '0;

   int   samples_in   = 0;
   int   rates_out    = 0;
   int   mismatches   = 0;
   int   stall_cycles = 0;
   int   hold_left    = 0;
   bit   hold_done    = 1'b0;
   logic calm;

   assign calm = (samples_in >= 500) && (samples_in < 800);

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic rate_beat_type predict_crossing_rate(input logic [SAMPLE_W-1:0] smp);
      zcrw_pkg::sign_type s;
      logic               crossing;
      int unsigned        eff_window;
      longint unsigned    q;
      rate_beat_type      beat;
      if (smp == '0) s = zcrw_pkg::SIGN_ZERO;
      else if (smp[SAMPLE_W-1]) s = zcrw_pkg::SIGN_NEG;
      else s = zcrw_pkg::SIGN_POS;
      if (s == zcrw_pkg::SIGN_ZERO) begin
         crossing = !zero_run;
         zero_run = 1'b1;
      end else begin
         zero_run = 1'b0;
         crossing = (s == zcrw_pkg::SIGN_POS && last_sign == zcrw_pkg::SIGN_NEG) ||
                    (s == zcrw_pkg::SIGN_NEG && last_sign == zcrw_pkg::SIGN_POS);
      end
      last_sign    = s;
      crossing_sum = crossing_sum + crossing;
      eff_window   = window_size_reg;
      if (eff_window == 0) eff_window = 1;
      if (eff_window > zcrw_pkg::MAX_WINDOW_DEF) eff_window = zcrw_pkg::MAX_WINDOW_DEF;
      beat.window_end = 1'b0;
      if (int'(window_fill) + 1 >= eff_window) begin
         q = (longint'(crossing_sum) << 16) / eff_window;
         held_rate       = (q > 65535) ? 16'hFFFF : q[15:0];
         crossing_sum    = '0;
         window_fill     = '0;
         beat.window_end = 1'b1;
      end else begin
         window_fill = window_fill + 1'b1;
      end
      beat.rate = held_rate;
      return beat;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      int                  r;
      logic [SAMPLE_W-1:0] v;
      r = $urandom_range(99);
      if (r < 20) begin
         v = '0;
      end else if (r < 35) begin
         case ($urandom_range(3))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0001;
            default: v = 16'hFFFF;
         endcase
      end else if (r < 70) begin
         v = SAMPLE_W'($urandom);
      end else begin
         v = SAMPLE_W'($urandom_range(1, 4));
         if ($urandom_range(1)) v = -v;
      end
      return v;
   endfunction

   task automatic report_mismatch(input string what, input rate_beat_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t (%s): expected rate %h end %b, got rate %h end %b",
                  $realtime, what, want.rate, want.window_end, rsp_tdata, rsp_tlast);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rate_q.push_back(predict_crossing_rate(req_tdata));
            samples_in <= samples_in + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (sample_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= sample_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rates_out++;
            if (rate_q.size() == 0) begin
               report_mismatch("no beat expected", '0);
            end else begin
               rate_beat_type want;
               want = rate_q.pop_front();
               if (want.rate !== rsp_tdata || want.window_end !== rsp_tlast)
                  report_mismatch("beat", want);
            end
         end
         if (hold_left > 0) hold_left--;
         if (!hold_done && rates_out == HOLD_AT_BEAT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         rsp_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("zero_crossing_rate_window_core_tb failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic wait_drained();
      while (!(sample_q.size() == 0 && !req_tvalid && rate_q.size() == 0))
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_window_size();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= zcrw_pkg::CSR_ADDR_W'(4 * zcrw_pkg::REG_WINDOW_SIZE);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== zcrw_pkg::CSR_DATA_W'(window_size_reg)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch at %0t (window_size read): expected %h, got %h",
                     $realtime, window_size_reg, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_window_size(input logic [zcrw_pkg::WS_W-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= zcrw_pkg::CSR_ADDR_W'(4 * zcrw_pkg::REG_WINDOW_SIZE);
      csr_pwdata  <= zcrw_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      window_size_reg = value;
      check_window_size();
   endtask

   task automatic push_random(input int count);
      repeat (count) sample_q.push_back(random_sample());
   endtask

   initial begin
      logic [SAMPLE_W-1:0]       directed[];
      logic [SAMPLE_W-1:0]       mag;
      logic [zcrw_pkg::WS_W-1:0] size;
      int                        pick;

      directed = '{
         16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000,
         16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'hFFFF, 16'h7FFF,
         16'h0001, 16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      check_window_size();
      foreach (directed[i]) sample_q.push_back(directed[i]);

      set_window_size('0);
      push_random(24);
      set_window_size(13'd1);
      push_random(24);
      set_window_size(13'h1FFF);
      push_random(200);
      // shrink below the fill level: next beat closes the window
      set_window_size(13'd5);
      push_random(30);

      // alternate signs across two windows to hit full rate
      set_window_size(13'd512);
      for (int i = 0; i < 1024; i++) begin
         mag = SAMPLE_W'($urandom_range(1, 32767));
         if ($urandom_range(15) == 0) mag = 16'h7FFF;
         if (i % 2) begin
            if ($urandom_range(15) == 0) sample_q.push_back(16'h8000);
            else sample_q.push_back(-mag);
         end else begin
            sample_q.push_back(mag);
         end
      end

      set_window_size(13'd2);
      push_random(40);

      repeat (4) begin
         pick = $urandom_range(99);
         if (pick < 70) size = zcrw_pkg::WS_W'($urandom_range(2, 40));
         else if (pick < 90) size = zcrw_pkg::WS_W'($urandom_range(41, 300));
         else size = zcrw_pkg::WS_W'($urandom_range(0, 8191));
         set_window_size(size);
         push_random($urandom_range(60, 140));
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("zero_crossing_rate_window_core_tb passed");
      end else begin
         $display("zero_crossing_rate_window_core_tb failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/zcrw_pkg.sv
hw/rtl/zcrw_sign_scan.sv
hw/rtl/zcrw_divider.sv
hw/rtl/zcrw_csr.sv
hw/rtl/zero_crossing_rate_window_core.sv
tb/sv/zero_crossing_rate_window_core_tb.sv
